// ===== src/isms_pkg.sv =====
package isms_pkg;
  localparam int MaxRanges = 64;
  localparam int ValueBits = 16;
  localparam int IdxW = $clog2(MaxRanges);
  localparam int CntW = $clog2(MaxRanges + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // datapath commands
  typedef struct packed {
    logic            rd;      // read entry at rd_idx
    logic [IdxW-1:0] rd_idx;
    logic            wr;      // write entry
    logic [IdxW-1:0] wr_idx;
    logic [1:0]      wr_sel;  // 0 read data, 1 given pair
    logic [ValueBits-1:0] wr_s;
    logic [ValueBits-1:0] wr_e;
  } dp_cmd_t;

  typedef struct packed {
    logic [ValueBits-1:0] s;
    logic [ValueBits-1:0] e;
  } dp_sts_t;

  localparam logic [1:0] WrRead = 2'd0;
  localparam logic [1:0] WrPair = 2'd1;
endpackage

// ===== src/isms_dp.sv =====
module isms_dp (
  input  logic              clk_i,
  input  isms_pkg::dp_cmd_t cmd_i,
  output isms_pkg::dp_sts_t sts_o
);
  import isms_pkg::*;

  logic [ValueBits-1:0] starts_mem [MaxRanges];
  logic [ValueBits-1:0] ends_mem [MaxRanges];
  logic [ValueBits-1:0] s_q, e_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      s_q <= starts_mem[cmd_i.rd_idx];
      e_q <= ends_mem[cmd_i.rd_idx];
    end
    if (cmd_i.wr) begin
      if (cmd_i.wr_sel == WrRead) begin
        starts_mem[cmd_i.wr_idx] <= s_q;
        ends_mem[cmd_i.wr_idx]   <= e_q;
      end else begin
        starts_mem[cmd_i.wr_idx] <= cmd_i.wr_s;
        ends_mem[cmd_i.wr_idx]   <= cmd_i.wr_e;
      end
    end
  end

  assign sts_o.s = s_q;
  assign sts_o.e = e_q;
endmodule

// ===== src/isms_ctrl.sv =====
module isms_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [isms_pkg::ValueBits-1:0] range_start_i,
  input  logic [isms_pkg::ValueBits-1:0] range_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic [5:0]                     hit_index_o,
  output logic [1:0]                     status_o,
  output logic [6:0]                     range_count_o,
  output isms_pkg::dp_cmd_t              cmd_o,
  input  isms_pkg::dp_sts_t              sts_i
);
  import isms_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,  // read issued for i_q
    S_EVAL  = 9'b000000100,  // data of i_q available
    S_MSCAN = 9'b000001000,  // merge scan forward
    S_MEVAL = 9'b000010000,
    S_SHUP  = 9'b000100000,  // open slot, walking down
    S_SHUPW = 9'b001000000,
    S_SHDN  = 9'b010000000,  // close gap, walking up
    S_DONE  = 9'b100000000
  } state_e;

  localparam logic [CntW:0] MaxC = (CntW+1)'(MaxRanges);

  state_e state_q, state_d;
  logic [1:0]           op_q;
  logic [ValueBits-1:0] s_q, e_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      i_q, i_d;     // found position
  logic [CntW-1:0]      j_q, j_d;     // scan/shift index
  logic [CntW-1:0]      k_q, k_d;     // drop start
  logic [ValueBits-1:0] hi_q, hi_d;
  logic [ValueBits-1:0] ps_q, ps_d, pe_q, pe_d; // pair to place after open
  logic [ValueBits-1:0] rs_q, rs_d, re_q, re_d; // second pair for split
  logic                 split_q, split_d;
  logic                 found_q, found_d;
  logic [1:0]           st_q, st_d;
  dp_cmd_t              cmd;

  logic [ValueBits:0] s_ext, e_ext, rs_ext, re_ext;
  assign s_ext  = {1'b0, s_q};
  assign e_ext  = {1'b0, e_q};
  assign rs_ext = {1'b0, sts_i.s};
  assign re_ext = {1'b0, sts_i.e};

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_DONE;
  assign found_o     = found_q;
  assign hit_index_o = 6'(i_q);
  assign status_o    = st_q;
  assign range_count_o = 7'(cnt_q);
  assign cmd_o = cmd;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; k_d = k_q;
    hi_d = hi_q; ps_d = ps_q; pe_d = pe_q; rs_d = rs_q; re_d = re_q;
    split_d = split_q; found_d = found_q; st_d = st_q;
    cmd = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        found_d = 1'b0; st_d = ST_OK; i_d = '0; j_d = '0;
        if (op_i == OP_CLEAR) begin
          cnt_d = '0; state_d = S_DONE;
        end else if (op_i != OP_LOOKUP && range_start_i > range_end_i) begin
          st_d = ST_BAD; state_d = S_DONE;
        end else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (i_q == cnt_q) begin
          // nothing at or past the point
          if (op_q == OP_INSERT) begin
            if ({1'b0, cnt_q} >= MaxC) st_d = ST_FULL;
            else begin
              ps_d = s_q; pe_d = e_q; split_d = 1'b0;
              j_d = cnt_q; cnt_d = cnt_q + 1'b1; state_d = S_SHUP;
            end
            if ({1'b0, cnt_q} >= MaxC) begin
              i_d = '0; state_d = S_DONE;
            end
          end else begin
            i_d = '0;
            state_d = S_DONE;
          end
        end else begin
          cmd.rd = 1'b1; cmd.rd_idx = IdxW'(i_q); state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        case (op_q)
          OP_LOOKUP: begin
            if (sts_i.s <= s_q && s_q <= sts_i.e) begin
              found_d = 1'b1; state_d = S_DONE;
            end else begin
              i_d = i_q + 1'b1; state_d = S_SCAN;
            end
          end
          OP_INSERT: begin
            if (re_ext + 1'b1 < s_ext) begin
              i_d = i_q + 1'b1; state_d = S_SCAN;
            end else if (rs_ext > e_ext + 1'b1) begin
              if ({1'b0, cnt_q} >= MaxC) begin
                st_d = ST_FULL; i_d = '0; state_d = S_DONE;
              end else begin
                ps_d = s_q; pe_d = e_q; split_d = 1'b0;
                j_d = cnt_q; cnt_d = cnt_q + 1'b1; state_d = S_SHUP;
              end
            end else begin
              ps_d = (s_q < sts_i.s) ? s_q : sts_i.s;
              hi_d = sts_i.e; j_d = i_q + 1'b1; state_d = S_MSCAN;
            end
          end
          default: begin // remove
            if (sts_i.e < s_q) begin
              i_d = i_q + 1'b1; state_d = S_SCAN;
            end else if (sts_i.s > e_q) begin
              i_d = '0; state_d = S_DONE;
            end else if (sts_i.s < s_q && sts_i.e > e_q) begin
              if ({1'b0, cnt_q} >= MaxC) begin
                st_d = ST_FULL; i_d = '0; state_d = S_DONE;
              end else begin
                ps_d = sts_i.s; pe_d = s_q - 1'b1;
                rs_d = e_q + 1'b1; re_d = sts_i.e; split_d = 1'b1;
                j_d = cnt_q; cnt_d = cnt_q + 1'b1; state_d = S_SHUP;
              end
            end else begin
              if (sts_i.s < s_q) begin
                cmd.wr = 1'b1; cmd.wr_idx = IdxW'(i_q); cmd.wr_sel = WrPair;
                cmd.wr_s = sts_i.s; cmd.wr_e = s_q - 1'b1;
                k_d = i_q + 1'b1; j_d = i_q + 1'b1;
              end else begin
                k_d = i_q; j_d = i_q;
              end
              state_d = S_MSCAN;
            end
          end
        endcase
      end
      S_MSCAN: begin
        if (j_q == cnt_q) begin
          if (op_q == OP_INSERT) begin
            cmd.wr = 1'b1; cmd.wr_idx = IdxW'(i_q); cmd.wr_sel = WrPair;
            cmd.wr_s = ps_q; cmd.wr_e = (e_q > hi_q) ? e_q : hi_q;
            k_d = i_q + 1'b1;
          end
          // drop [k, j): shift from j
          hi_d = ValueBits'(j_q - k_d);
          cnt_d = cnt_q - (j_q - k_d);
          i_d = k_d;          // write pointer
          state_d = S_SHDN;
        end else begin
          cmd.rd = 1'b1; cmd.rd_idx = IdxW'(j_q); state_d = S_MEVAL;
        end
      end
      S_MEVAL: begin
        if (op_q == OP_INSERT) begin
          if (rs_ext <= e_ext + 1'b1) begin
            hi_d = sts_i.e; j_d = j_q + 1'b1; state_d = S_MSCAN;
          end else begin
            cmd.wr = 1'b1; cmd.wr_idx = IdxW'(i_q); cmd.wr_sel = WrPair;
            cmd.wr_s = ps_q; cmd.wr_e = (e_q > hi_q) ? e_q : hi_q;
            k_d = i_q + 1'b1;
            cnt_d = cnt_q - (j_q - k_d);
            i_d = k_d; state_d = S_SHDN;
          end
        end else begin
          if (sts_i.e <= e_q) begin
            j_d = j_q + 1'b1; state_d = S_MSCAN;
          end else begin
            if (sts_i.s <= e_q) begin
              cmd.wr = 1'b1; cmd.wr_idx = IdxW'(j_q); cmd.wr_sel = WrPair;
              cmd.wr_s = e_q + 1'b1; cmd.wr_e = sts_i.e;
            end
            cnt_d = cnt_q - (j_q - k_q);
            i_d = k_q; state_d = S_SHDN;
          end
        end
      end
      S_SHDN: begin
        // i_q write ptr, j_q read ptr; cnt_q already final
        if (i_q == cnt_q) begin
          i_d = '0; state_d = S_DONE;
        end else if (k_q == '1) begin
          cmd.wr = 1'b1; cmd.wr_idx = IdxW'(i_q); cmd.wr_sel = WrRead;
          i_d = i_q + 1'b1; j_d = j_q + 1'b1; k_d = '0;
        end else begin
          cmd.rd = 1'b1; cmd.rd_idx = IdxW'(j_q); k_d = '1;
        end
      end
      S_SHUP: begin
        // j_q is the slot being filled, walking down to i_q
        if (j_q == i_q) begin
          cmd.wr = 1'b1; cmd.wr_idx = IdxW'(i_q); cmd.wr_sel = WrPair;
          cmd.wr_s = ps_q; cmd.wr_e = pe_q;
          if (split_q) begin
            ps_d = rs_q; pe_d = re_q; split_d = 1'b0;
            i_d = i_q + 1'b1; j_d = i_q + 1'b1;
          end else begin
            i_d = '0; state_d = S_DONE;
          end
        end else begin
          cmd.rd = 1'b1; cmd.rd_idx = IdxW'(j_q - 1'b1); state_d = S_SHUPW;
        end
      end
      S_SHUPW: begin
        cmd.wr = 1'b1; cmd.wr_idx = IdxW'(j_q); cmd.wr_sel = WrRead;
        j_d = j_q - 1'b1; state_d = S_SHUP;
      end
      S_DONE: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_DONE && op_q != OP_LOOKUP) i_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      found_q <= 1'b0;
      st_q <= ST_OK;
      i_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      found_q <= found_d;
      st_q <= st_d;
      i_q <= i_d;
      // in shift-down, k_q is the read/write phase flag
      if (state_q != S_SHDN && state_d == S_SHDN) k_q <= '0;
      else k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= op_i; s_q <= range_start_i; e_q <= range_end_i;
    end
    j_q <= j_d; hi_q <= hi_d; ps_q <= ps_d; pe_q <= pe_d;
    rs_q <= rs_d; re_q <= re_d; split_q <= split_d;
  end
endmodule

// ===== src/interval_set_merge_split.sv =====
// operation: lookup scans entries, reading each in S_SCAN and testing it in S_EVAL; insert/remove scan up
// to count entries, then merge or shift entries, each read and then written, before the result beat
// throughput: one beat in flight; next input accepted the cycle after the result beat
// clear, and insert/remove with reversed ranges, give their result in the cycle after the input beat
// reset: range count cleared to zero, table contents left undefined
module interval_set_merge_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] range_start_i,
  input  logic [15:0] range_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [5:0]  hit_index_o,
  output logic [1:0]  status_o,
  output logic [6:0]  range_count_o
);
  import isms_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  isms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i,
    .range_start_i(range_start_i[ValueBits-1:0]),
    .range_end_i(range_end_i[ValueBits-1:0]),
    .out_valid_o, .out_ready_i, .found_o, .hit_index_o, .status_o, .range_count_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  isms_dp u_dp (.clk_i, .cmd_i(cmd), .sts_o(sts));
endmodule

// ===== tb/sv/isms_checker.sv =====
module isms_checker
  import isms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] range_start_i,
  input  logic [15:0] range_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [5:0]  hit_index_i,
  input  logic [1:0]  status_i,
  input  logic [6:0]  range_count_i,
  output int          errors_o,
  output int          pending_o,
  output int          n_full_o,
  output int          n_split_o
);

  typedef struct packed {
    logic       found;
    logic [5:0] hit;
    status_e    status;
    logic [6:0] cnt;
  } answer_t;

  logic [15:0] lo_q [MaxRanges];
  logic [15:0] hi_q [MaxRanges];
  int          num_ranges;
  answer_t     answers_q [$];

  function automatic void drop_ranges(int from, int to);
    int n;
    n = to - from;
    if (n <= 0) return;
    for (int k = to; k < num_ranges; k++) begin
      lo_q[k-n] = lo_q[k];
      hi_q[k-n] = hi_q[k];
    end
    num_ranges -= n;
  endfunction

  function automatic void open_gap(int pos);
    for (int k = num_ranges; k > pos; k--) begin
      lo_q[k] = lo_q[k-1];
      hi_q[k] = hi_q[k-1];
    end
    num_ranges++;
  endfunction

  function automatic status_e merge_range(int s, int e);
    int i, j, top;
    i = 0;
    while (i < num_ranges && int'(hi_q[i]) + 1 < s) i++;
    if (i == num_ranges || int'(lo_q[i]) > e + 1) begin
      if (num_ranges >= MaxRanges) return ST_FULL;
      open_gap(i);
      lo_q[i] = 16'(s);
      hi_q[i] = 16'(e);
      return ST_OK;
    end
    if (s < lo_q[i]) lo_q[i] = 16'(s);
    top = hi_q[i];
    j = i + 1;
    while (j < num_ranges && int'(lo_q[j]) <= e + 1) begin
      top = hi_q[j];
      j++;
    end
    if (e > top) top = e;
    hi_q[i] = 16'(top);
    drop_ranges(i + 1, j);
    return ST_OK;
  endfunction

  function automatic status_e carve_range(int s, int e);
    int i, j, k;
    i = 0;
    while (i < num_ranges && int'(hi_q[i]) < s) i++;
    if (i == num_ranges || int'(lo_q[i]) > e) return ST_OK;
    if (lo_q[i] < s && hi_q[i] > e) begin
      if (num_ranges >= MaxRanges) return ST_FULL;
      n_split_o++;
      open_gap(i);
      hi_q[i] = 16'(s - 1);
      lo_q[i+1] = 16'(e + 1);
      return ST_OK;
    end
    k = i;
    if (lo_q[i] < s) begin
      hi_q[i] = 16'(s - 1);
      k = i + 1;
    end
    j = k;
    while (j < num_ranges && int'(hi_q[j]) <= e) j++;
    if (j < num_ranges && int'(lo_q[j]) <= e) lo_q[j] = 16'(e + 1);
    drop_ranges(k, j);
    return ST_OK;
  endfunction

  function automatic answer_t apply_op(op_e op, int s, int e);
    answer_t a;
    a = '0;
    a.status = ST_OK;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < num_ranges; i++)
        if (lo_q[i] <= s && s <= hi_q[i]) begin
          a.found = 1'b1;
          a.hit = i[5:0];
          break;
        end
    end else if (op == OP_CLEAR) begin
      num_ranges = 0;
    end else if (s > e) begin
      a.status = ST_BAD;
    end else if (op == OP_INSERT) begin
      a.status = merge_range(s, e);
    end else begin
      a.status = carve_range(s, e);
    end
    if (a.status == ST_FULL) n_full_o++;
    a.cnt = num_ranges[6:0];
    return a;
  endfunction

  assign pending_o = answers_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      num_ranges = 0;
      answers_q.delete();
      errors_o = 0;
      n_full_o = 0;
      n_split_o = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        answers_q = {answers_q, apply_op(op_e'(op_i), int'(range_start_i),
                                         int'(range_end_i))};
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors_o++;
        end else begin
          exp_a = answers_q.pop_front();
          if (found_i !== exp_a.found || hit_index_i !== exp_a.hit ||
              status_i !== exp_a.status || range_count_i !== exp_a.cnt) begin
            $display("%0t: mismatch expected found=%0d hit=%0d status=%0d count=%0d",
                     $time, exp_a.found, exp_a.hit, exp_a.status, exp_a.cnt);
            $display("%0t:          actual   found=%0d hit=%0d status=%0d count=%0d",
                     $time, found_i, hit_index_i, status_i, range_count_i);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import isms_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_LOOKUP;
  logic [15:0] range_start = '0;
  logic [15:0] range_end = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [5:0]  hit_index;
  logic [1:0]  status;
  logic [6:0]  range_count;
  int          errors, pending, n_full, n_split;
  int          n_sent;
  bit          stall_mode = 1'b0;

  always #5 clk = ~clk;

  interval_set_merge_split u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .range_start_i(range_start), .range_end_i(range_end),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .found_o(found), .hit_index_o(hit_index), .status_o(status),
    .range_count_o(range_count)
  );

  isms_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .op_i(op), .range_start_i(range_start), .range_end_i(range_end),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .found_i(found), .hit_index_i(hit_index), .status_i(status),
    .range_count_i(range_count),
    .errors_o(errors), .pending_o(pending), .n_full_o(n_full), .n_split_o(n_split)
  );

  // receiver stall pattern, switching between always-ready and random stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task automatic send_beat(op_e o, logic [15:0] s, logic [15:0] e);
    in_valid <= 1'b1;
    op <= o;
    range_start <= s;
    range_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic idle_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // values clustered in a small window so ranges touch, overlap and split
  function automatic logic [15:0] pick_value(int window);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(32'hffff - $urandom_range(0, 3));
    if (r == 1) return 16'($urandom_range(0, 3));
    if (r == 2) return 16'($urandom());
    return 16'($urandom_range(0, window));
  endfunction

  task automatic random_beat(int window, int ins_weight);
    logic [15:0] s, e;
    int r, d;
    op_e o;
    r = $urandom_range(0, 99);
    if (r < 2) o = OP_CLEAR;
    else if (r < 25) o = OP_LOOKUP;
    else if (r < 25 + ins_weight) o = OP_INSERT;
    else o = OP_REMOVE;
    s = pick_value(window);
    d = $urandom_range(0, 6);
    if ($urandom_range(0, 19) == 0) e = pick_value(window);
    else e = (int'(s) + d > 32'hffff) ? 16'hffff : 16'(int'(s) + d);
    send_beat(o, s, e);
  endtask

  initial begin
    int burst;
    n_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_beat(OP_LOOKUP, 16'd0, 16'd0);
    send_beat(OP_INSERT, 16'd10, 16'd20);
    send_beat(OP_INSERT, 16'd21, 16'd25);
    send_beat(OP_INSERT, 16'd30, 16'd40);
    send_beat(OP_INSERT, 16'd26, 16'd29);
    send_beat(OP_INSERT, 16'hfff0, 16'hffff);
    send_beat(OP_INSERT, 16'd0, 16'd0);
    send_beat(OP_LOOKUP, 16'd15, 16'hffff);
    send_beat(OP_LOOKUP, 16'hffff, 16'd0);
    send_beat(OP_LOOKUP, 16'd1, 16'd0);
    send_beat(OP_INSERT, 16'd50, 16'd40);
    send_beat(OP_REMOVE, 16'hffff, 16'd0);
    send_beat(OP_REMOVE, 16'd20, 16'd22);
    send_beat(OP_REMOVE, 16'd5, 16'd12);
    send_beat(OP_REMOVE, 16'hffff, 16'hffff);
    send_beat(OP_REMOVE, 16'd0, 16'hffff);
    send_beat(OP_CLEAR, 16'hffff, 16'hffff);
    // fill the table, then insert and remove on the full table
    for (int i = 0; i < MaxRanges; i++)
      send_beat(OP_INSERT, 16'(i * 4), 16'(i * 4 + 1));
    send_beat(OP_INSERT, 16'd1000, 16'd1000);
    send_beat(OP_INSERT, 16'd2, 16'd2);
    send_beat(OP_REMOVE, 16'd4, 16'd4);
    send_beat(OP_REMOVE, 16'd8, 16'd9);
    send_beat(OP_LOOKUP, 16'd253, 16'd0);
    send_beat(OP_CLEAR, 16'd0, 16'd0);

    // hold off until every result is back
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    while (n_sent < 1850) begin
      burst = $urandom_range(1, 20);
      repeat (burst) random_beat(n_sent < 900 ? 120 : 300, n_sent % 600 < 300 ? 55 : 35);
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 15));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d beats: lookup/insert/remove/clear, %0d table-full answers, %0d splits",
             n_sent, n_full, n_split);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== interval_set_merge_split.f =====
src/isms_pkg.sv
src/isms_dp.sv
src/isms_ctrl.sv
src/interval_set_merge_split.sv
tb/sv/isms_checker.sv
tb/sv/testbench.sv
